[rtl/core/sts_pkg.sv]
// ============================================================================
// Slot table thread scheduler package
// Shared codes, widths and control bundles of the scheduler core.
// ============================================================================
package sts_pkg;

    localparam int TID_W       = 4;
    localparam int NUM_THREADS = 16;
    localparam int CMD_W       = 3;
    localparam int EV_IN_W     = 8;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 5;

    // Commands.
    localparam logic [CMD_W-1:0] CMD_SET_READY   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET_WAITING = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WAKE_EVENT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET_EXIT    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESCHEDULE  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_FIND_THREAD = 3'd5;

    // Thread states.
    localparam logic [1:0] TS_READY   = 2'd0;
    localparam logic [1:0] TS_WAITING = 2'd1;
    localparam logic [1:0] TS_EXITED  = 2'd2;
    localparam logic [1:0] TS_IDLE    = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONE    = 2'd2;

    // Write and clear strobes from the sequencer to one slot table.
    typedef struct packed {
        logic wr;
        logic clr;
    } tbl_ctl_t;

    // Registered view of the slot last read, plus the full flag.
    typedef struct packed {
        logic used;
        logic full;
    } tbl_sts_t;

    // One finished result, before the counts are attached.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TID_W-1:0]    thread;
    } res_t;

endpackage

[rtl/core/sts_slot_table.sv]
// ============================================================================
// Slot table
// Synchronous slot memory with used bits, fill total and round-robin pointer.
// ============================================================================
module sts_slot_table #(
    parameter int SLOTS = 16,
    parameter int DW    = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  sts_pkg::tbl_ctl_t            ctl,
    input  logic [$clog2(SLOTS)-1:0]     rd_addr,
    input  logic [$clog2(SLOTS)-1:0]     wr_addr,
    input  logic [DW-1:0]                wr_data,
    output logic [DW-1:0]                rd_data,
    output sts_pkg::tbl_sts_t            sts,
    output logic [$clog2(SLOTS)-1:0]     ptr,
    output logic [$clog2(SLOTS+1)-1:0]   total
);
    import sts_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS+1);

    logic [DW-1:0]    slot_mem [SLOTS];
    logic [DW-1:0]    rd_data_reg;
    logic             rd_used_reg;
    logic [SLOTS-1:0] used_reg, used_next;
    logic [AW-1:0]    ptr_reg, ptr_next;
    logic [CW-1:0]    total_reg, total_next;

    // Slot contents: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (ctl.wr) begin
            slot_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= slot_mem[rd_addr];
    end

    always_comb begin
        used_next  = used_reg;
        ptr_next   = ptr_reg;
        total_next = total_reg;
        if (ctl.wr) begin
            used_next[wr_addr] = 1'b1;
            total_next         = total_reg + CW'(1);
        end else if (ctl.clr) begin
            used_next[wr_addr] = 1'b0;
            total_next         = total_reg - CW'(1);
            ptr_next           = (wr_addr == AW'(SLOTS-1)) ? '0 : wr_addr + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg    <= '0;
            ptr_reg     <= '0;
            total_reg   <= '0;
            rd_used_reg <= 1'b0;
        end else begin
            used_reg    <= used_next;
            ptr_reg     <= ptr_next;
            total_reg   <= total_next;
            rd_used_reg <= used_reg[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign sts.used = rd_used_reg;
    assign sts.full = (total_reg == CW'(SLOTS));
    assign ptr      = ptr_reg;
    assign total    = total_reg;

endmodule

[rtl/core/sts_ctrl.sv]
// ============================================================================
// Scheduler sequencer
// Decodes commands, keeps thread states and scans the slot tables.
// ============================================================================
module sts_ctrl #(
    parameter int SLOTS = 16,
    parameter int EW    = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [sts_pkg::CMD_W-1:0]       in_cmd,
    input  logic [sts_pkg::TID_W-1:0]       in_tid,
    input  logic [EW-1:0]                   in_ev,
    output logic                            res_valid,
    input  logic                            res_ready,
    output sts_pkg::res_t                   res,
    output logic [$clog2(SLOTS)-1:0]        scan_addr,
    output logic [$clog2(SLOTS)-1:0]        slot_addr,
    output logic [sts_pkg::TID_W-1:0]       r_wr_data,
    output logic [sts_pkg::TID_W+EW-1:0]    w_wr_data,
    output sts_pkg::tbl_ctl_t               r_ctl,
    output sts_pkg::tbl_ctl_t               w_ctl,
    input  logic [sts_pkg::TID_W-1:0]       r_data,
    input  sts_pkg::tbl_sts_t               r_sts,
    input  logic [$clog2(SLOTS)-1:0]        r_ptr,
    input  logic [sts_pkg::TID_W+EW-1:0]    w_data,
    input  sts_pkg::tbl_sts_t               w_sts,
    input  logic [$clog2(SLOTS)-1:0]        w_ptr
);
    import sts_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int KW = $clog2(SLOTS+1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECODE = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    localparam logic [2:0] M_INS    = 3'd0;
    localparam logic [2:0] M_POP    = 3'd1;
    localparam logic [2:0] M_WAKE   = 3'd2;
    localparam logic [2:0] M_FIND_R = 3'd3;
    localparam logic [2:0] M_FIND_W = 3'd4;

    logic [1:0]       state_reg, state_next;
    logic [2:0]       mode_reg, mode_next;
    logic [CMD_W-1:0] cmd_reg, cmd_next;
    logic [TID_W-1:0] tid_reg, tid_next;
    logic [EW-1:0]    ev_reg, ev_next;
    logic [AW-1:0]    base_reg, base_next;
    logic [KW-1:0]    k_reg, k_next;
    logic             vd_reg, vd_next;
    logic [AW-1:0]    ad_reg, ad_next;
    logic             lastd_reg, lastd_next;
    logic             drop_reg, drop_next;
    res_t             res_reg, res_next;
    logic [1:0]       tstat_reg [NUM_THREADS];
    logic [1:0]       tstat_next [NUM_THREADS];

    logic [AW:0]      addr_sum;
    logic [TID_W-1:0] st_addr;
    logic [1:0]       st;
    logic             use_w;
    logic             used_d;
    logic             w_hit_ev;
    logic [TID_W-1:0] w_thread;

    assign addr_sum  = {1'b0, base_reg} + (AW+1)'(k_reg);
    assign scan_addr = (addr_sum >= (AW+1)'(SLOTS)) ? AW'(addr_sum - (AW+1)'(SLOTS))
                                                    : AW'(addr_sum);
    assign slot_addr = ad_reg;
    assign r_wr_data = tid_reg;
    assign w_wr_data = {ev_reg, tid_reg};
    assign w_thread  = w_data[TID_W-1:0];
    assign w_hit_ev  = (w_data[TID_W+EW-1:TID_W] == ev_reg);

    // During a pop the state is looked up for the thread just read back.
    assign st_addr = (state_reg == S_SCAN && mode_reg == M_POP) ? r_data : tid_reg;
    assign st      = tstat_reg[st_addr];

    assign use_w = (mode_reg == M_WAKE) || (mode_reg == M_FIND_W) ||
                   (mode_reg == M_INS && cmd_reg == CMD_SET_WAITING);
    assign used_d = use_w ? w_sts.used : r_sts.used;

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        cmd_next   = cmd_reg;
        tid_next   = tid_reg;
        ev_next    = ev_reg;
        base_next  = base_reg;
        k_next     = k_reg;
        vd_next    = vd_reg;
        ad_next    = ad_reg;
        lastd_next = lastd_reg;
        drop_next  = drop_reg;
        res_next   = res_reg;
        tstat_next = tstat_reg;
        r_ctl      = '0;
        w_ctl      = '0;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd_next   = in_cmd;
                    tid_next   = in_tid;
                    ev_next    = in_ev;
                    state_next = S_DECODE;
                end
            end

            S_DECODE: begin
                k_next    = '0;
                vd_next   = 1'b0;
                drop_next = 1'b0;
                base_next = '0;
                state_next = S_SCAN;
                case (cmd_reg)
                    CMD_SET_READY: begin
                        res_next = '{status: ST_DONE, thread: tid_reg};
                        mode_next = M_INS;
                        if (st == TS_READY) begin
                            state_next = S_DONE;
                        end else if (r_sts.full) begin
                            res_next.status = ST_DROPPED;
                            state_next      = S_DONE;
                        end
                    end
                    CMD_SET_WAITING: begin
                        res_next = '{status: ST_DONE, thread: tid_reg};
                        mode_next = M_INS;
                        if (st == TS_WAITING) begin
                            state_next = S_DONE;
                        end else if (w_sts.full) begin
                            res_next.status = ST_DROPPED;
                            state_next      = S_DONE;
                        end
                    end
                    CMD_WAKE_EVENT: begin
                        mode_next = M_WAKE;
                        base_next = w_ptr;
                    end
                    CMD_SET_EXIT: begin
                        tstat_next[tid_reg] = TS_EXITED;
                        res_next   = '{status: ST_DONE, thread: tid_reg};
                        state_next = S_DONE;
                    end
                    CMD_RESCHEDULE: begin
                        mode_next = M_POP;
                        base_next = r_ptr;
                        if (st != TS_EXITED && st != TS_WAITING) begin
                            if (r_sts.full) begin
                                drop_next = 1'b1;
                            end else begin
                                mode_next = M_INS;
                                base_next = '0;
                            end
                        end
                    end
                    CMD_FIND_THREAD: begin
                        mode_next = M_FIND_R;
                    end
                    default: begin
                        res_next   = '{status: ST_DONE, thread: '0};
                        state_next = S_DONE;
                    end
                endcase
            end

            S_SCAN: begin
                // Read issue side: one slot address per cycle.
                vd_next    = (k_reg < KW'(SLOTS));
                ad_next    = scan_addr;
                lastd_next = (k_reg == KW'(SLOTS-1));
                if (k_reg < KW'(SLOTS)) begin
                    k_next = k_reg + KW'(1);
                end

                // Evaluate side: the slot whose data came back this cycle.
                if (vd_reg) begin
                    case (mode_reg)
                        M_INS: begin
                            if (!used_d) begin
                                if (cmd_reg == CMD_SET_WAITING) begin
                                    w_ctl.wr = 1'b1;
                                    tstat_next[tid_reg] = TS_WAITING;
                                end else begin
                                    r_ctl.wr = 1'b1;
                                    if (st != TS_EXITED) begin
                                        tstat_next[tid_reg] = TS_READY;
                                    end
                                end
                                if (cmd_reg == CMD_RESCHEDULE) begin
                                    // Requeued; now pop from the ready pointer.
                                    mode_next = M_POP;
                                    base_next = r_ptr;
                                    k_next    = '0;
                                    vd_next   = 1'b0;
                                end else begin
                                    state_next = S_DONE;
                                end
                            end else if (lastd_reg) begin
                                state_next = S_DONE;
                            end
                        end
                        M_POP: begin
                            if (r_sts.used) begin
                                r_ctl.clr = 1'b1;
                            end
                            if (r_sts.used && st != TS_EXITED) begin
                                res_next.status = drop_reg ? ST_DROPPED : ST_DONE;
                                res_next.thread = r_data;
                                state_next      = S_DONE;
                            end else if (lastd_reg) begin
                                res_next   = '{status: ST_NONE, thread: '0};
                                state_next = S_DONE;
                            end
                        end
                        M_WAKE: begin
                            if (w_sts.used && w_hit_ev) begin
                                w_ctl.clr  = 1'b1;
                                res_next   = '{status: ST_DONE, thread: w_thread};
                                state_next = S_DONE;
                            end else if (lastd_reg) begin
                                res_next   = '{status: ST_NONE, thread: '0};
                                state_next = S_DONE;
                            end
                        end
                        M_FIND_R: begin
                            if (r_sts.used && r_data == tid_reg) begin
                                res_next   = '{status: ST_DONE, thread: tid_reg};
                                state_next = S_DONE;
                            end else if (lastd_reg) begin
                                mode_next = M_FIND_W;
                                base_next = '0;
                                k_next    = '0;
                                vd_next   = 1'b0;
                            end
                        end
                        M_FIND_W: begin
                            if (w_sts.used && w_thread == tid_reg) begin
                                res_next   = '{status: ST_DONE, thread: tid_reg};
                                state_next = S_DONE;
                            end else if (lastd_reg) begin
                                res_next   = '{status: ST_NONE, thread: '0};
                                state_next = S_DONE;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mode_reg  <= M_INS;
            k_reg     <= '0;
            vd_reg    <= 1'b0;
            lastd_reg <= 1'b0;
            drop_reg  <= 1'b0;
            for (int i = 0; i < NUM_THREADS; i++) begin
                tstat_reg[i] <= TS_IDLE;
            end
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            k_reg     <= k_next;
            vd_reg    <= vd_next;
            lastd_reg <= lastd_next;
            drop_reg  <= drop_next;
            tstat_reg <= tstat_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        tid_reg  <= tid_next;
        ev_reg   <= ev_next;
        base_reg <= base_next;
        ad_reg   <= ad_next;
        res_reg  <= res_next;
    end

endmodule

[rtl/core/slot_table_thread_scheduler.sv]
// ============================================================================
// Slot table thread scheduler
// Ready and waiting slot tables with round-robin removal and event wake-up.
// ============================================================================
// Usage: one command enters on the s_ stream and exactly one result leaves on
// the m_ stream, in command order. Commands mark threads ready, waiting on an
// event or exited, wake the next waiter on an event, reschedule the current
// thread, or look a thread up by id.
// The block works on one command at a time. A command that needs no table
// scan goes from decode straight to its result. Each scan walks one slot per
// cycle through the slot memory's single registered read port; reschedule
// and find may run two scans, and a new command is accepted once the
// previous result has moved into the output register.
// The output register parts the two sides: a new command is taken while the
// previous result still waits, and when the receiver stalls the block holds
// its next result internally until the output register frees up.
// Reset (aresetn low at a clock edge) frees every slot, zeroes both
// round-robin pointers and marks all threads as not queued. Slot contents
// are not cleared; they are only read while their slot is in use.
// ============================================================================
module slot_table_thread_scheduler #(
    parameter int SLOTS      = 16,
    parameter int EVENT_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] cmd, [6:3] thread_id, [14:7] event_tag, [15] zero
    input  logic [15:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] status, [5:2] thread_out, [10:6] ready_count, [15:11] waiting_count
    output logic [15:0] m_tdata
);
    import sts_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS+1);
    // Only the low EVENT_BITS bits of the event tag take part in matching.
    localparam int EW = (EVENT_BITS < EV_IN_W) ? EVENT_BITS : EV_IN_W;
    localparam int WDW = TID_W + EW;

    logic               res_valid;
    logic               res_ready;
    res_t               res;
    logic [AW-1:0]      scan_addr;
    logic [AW-1:0]      slot_addr;
    logic [TID_W-1:0]   r_wr_data;
    logic [WDW-1:0]     w_wr_data;
    tbl_ctl_t           r_ctl;
    tbl_ctl_t           w_ctl;
    logic [TID_W-1:0]   r_data;
    logic [WDW-1:0]     w_data;
    tbl_sts_t           r_sts;
    tbl_sts_t           w_sts;
    logic [AW-1:0]      r_ptr;
    logic [AW-1:0]      w_ptr;
    logic [CW-1:0]      r_total;
    logic [CW-1:0]      w_total;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [15:0]        m_tdata_reg, m_tdata_next;

    sts_ctrl #(
        .SLOTS (SLOTS),
        .EW    (EW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tdata[2:0]),
        .in_tid    (s_tdata[6:3]),
        .in_ev     (s_tdata[7 +: EW]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .scan_addr (scan_addr),
        .slot_addr (slot_addr),
        .r_wr_data (r_wr_data),
        .w_wr_data (w_wr_data),
        .r_ctl     (r_ctl),
        .w_ctl     (w_ctl),
        .r_data    (r_data),
        .r_sts     (r_sts),
        .r_ptr     (r_ptr),
        .w_data    (w_data),
        .w_sts     (w_sts),
        .w_ptr     (w_ptr)
    );

    // Ready table: one thread id per slot.
    sts_slot_table #(
        .SLOTS (SLOTS),
        .DW    (TID_W)
    ) u_ready_tbl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (r_ctl),
        .rd_addr (scan_addr),
        .wr_addr (slot_addr),
        .wr_data (r_wr_data),
        .rd_data (r_data),
        .sts     (r_sts),
        .ptr     (r_ptr),
        .total   (r_total)
    );

    // Waiting table: event tag above the thread id in each slot.
    sts_slot_table #(
        .SLOTS (SLOTS),
        .DW    (WDW)
    ) u_wait_tbl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (w_ctl),
        .rd_addr (scan_addr),
        .wr_addr (slot_addr),
        .wr_data (w_wr_data),
        .rd_data (w_data),
        .sts     (w_sts),
        .ptr     (w_ptr),
        .total   (w_total)
    );

    // The output register takes a new result once its current one has left.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            // Counts are sampled here, after every table update of the command.
            m_tvalid_next = 1'b1;
            m_tdata_next  = {COUNT_W'(w_total), COUNT_W'(r_total), res.thread, res.status};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[rtl/core/sts_checker.sv]
// ============================================================================
// Scheduler port checker
// Concurrent checks on the stream ports of the thread scheduler.
// ============================================================================
module sts_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    import sts_pkg::*;

    // A stalled result stays put until the receiver takes it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // The block works on one command at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second command accepted while busy");

    // A failed search never names a thread.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == ST_NONE |-> m_tdata[5:2] == 4'd0)
        else $error("none-found result carries a thread id");

    // Status code three is never produced.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("undefined status code");

    // Reset leaves no result pending.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind slot_table_thread_scheduler sts_checker u_sts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[bench/slot_table_thread_scheduler_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// Slot table thread scheduler testbench
// Drives scheduler commands on the s_ stream and checks every result on the
// m_ stream against a cycle-free model of the ready and waiting slot tables.
// A short list of directed commands comes first, then random episodes that
// fill, drain and wake the tables, with random idle bursts on both sides.
// ============================================================================
module slot_table_thread_scheduler_tb;
    import sts_pkg::*;

    localparam int SLOTS       = 16;
    localparam int ITEMS       = 1900;
    localparam int QUIET_ITEMS = 150;
    localparam int DRAIN_WAIT  = 2 * SLOTS + 8;
    // Slowest legal run is about 2000 commands, each with two full scans plus
    // the longest sender gap and receiver stall.
    localparam longint RUN_LIMIT_NS = 64'd10_000_000;

    // The two command codes that the block must ignore.
    localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

    // One command as it travels in s_tdata, lowest field last here.
    typedef struct packed {
        logic               pad;
        logic [EV_IN_W-1:0] event_tag;
        logic [TID_W-1:0]   thread_id;
        logic [CMD_W-1:0]   cmd;
    } sched_cmd_t;

    // One result as it travels in m_tdata, lowest field last here.
    typedef struct packed {
        logic [COUNT_W-1:0]  waiting;
        logic [COUNT_W-1:0]  ready;
        logic [TID_W-1:0]    thread;
        logic [STATUS_W-1:0] status;
    } sched_result_t;

    // A directed row: the command, and where it is obvious, its result.
    typedef struct {
        sched_cmd_t    item;
        bit            typed;
        sched_result_t want;
    } dir_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [2:0] cmd, [6:3] thread_id, [14:7] event_tag, [15] zero
    logic [15:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [1:0] status, [5:2] thread_out, [10:6] ready_count, [15:11] waiting_count
    logic [15:0] m_tdata;

    // Model state: the two slot tables, their round-robin pointers and
    // counts, the per-thread state and the thread last chosen to run.
    logic                 rdy_used [SLOTS];
    logic [TID_W-1:0]     rdy_tid  [SLOTS];
    logic [3:0]           rdy_ptr;
    logic [COUNT_W-1:0]   rdy_cnt;
    logic                 wt_used  [SLOTS];
    logic [TID_W-1:0]     wt_tid   [SLOTS];
    logic [EV_IN_W-1:0]   wt_ev    [SLOTS];
    logic [3:0]           wt_ptr;
    logic [COUNT_W-1:0]   wt_cnt;
    logic [1:0]           thr_state [NUM_THREADS];
    logic [TID_W-1:0]     run_thread;

    sched_result_t sched_results_due[$];
    dir_row_t      dir_rows[$];

    int n_commands  = 0;
    int n_results   = 0;
    int n_mismatch  = 0;
    int n_dropped   = 0;
    int n_none      = 0;
    int gap_pct     = 0;
    int stall_pct   = 0;
    bit quiet       = 1'b0;

    always #4 aclk = ~aclk;

    slot_table_thread_scheduler #(
        .SLOTS      (SLOTS),
        .EVENT_BITS (8)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // ------------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------------

    // Put a thread into the lowest free ready slot. An exited thread is
    // queued but keeps its exited state. Returns 0 when the table is full.
    function automatic bit ready_slot_insert(input logic [TID_W-1:0] tid);
        if (rdy_cnt >= SLOTS)
            return 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (!rdy_used[i]) begin
                if (thr_state[tid] != TS_EXITED)
                    thr_state[tid] = TS_READY;
                rdy_used[i] = 1'b1;
                rdy_tid[i]  = tid;
                rdy_cnt++;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Apply one accepted command to the model and return its result.
    function automatic sched_result_t predict_schedule(input sched_cmd_t item);
        sched_result_t    r;
        logic [TID_W-1:0] tid;
        logic [TID_W-1:0] t;
        bit               dropped;
        bit               picked;
        bit               popping;
        int               p;
        r   = '0;
        tid = item.thread_id;
        t   = '0;
        case (item.cmd)
            CMD_SET_READY: begin
                r.thread = tid;
                if (thr_state[tid] != TS_READY && !ready_slot_insert(tid))
                    r.status = ST_DROPPED;
            end
            CMD_SET_WAITING: begin
                r.thread = tid;
                if (thr_state[tid] != TS_WAITING) begin
                    if (wt_cnt >= SLOTS) begin
                        r.status = ST_DROPPED;
                    end else begin
                        for (int i = 0; i < SLOTS; i++) begin
                            if (!wt_used[i]) begin
                                thr_state[tid] = TS_WAITING;
                                wt_used[i] = 1'b1;
                                wt_tid[i]  = tid;
                                wt_ev[i]   = item.event_tag;
                                wt_cnt++;
                                break;
                            end
                        end
                    end
                end
            end
            CMD_WAKE_EVENT: begin
                // The woken thread keeps its state; only the slot is freed.
                r.status = ST_NONE;
                for (int k = 0; k < SLOTS; k++) begin
                    p = (wt_ptr + k) % SLOTS;
                    if (wt_used[p] && wt_ev[p] == item.event_tag) begin
                        wt_used[p] = 1'b0;
                        wt_cnt--;
                        wt_ptr   = 4'((p + 1) % SLOTS);
                        r.thread = wt_tid[p];
                        r.status = ST_DONE;
                        break;
                    end
                end
            end
            CMD_SET_EXIT: begin
                r.thread = tid;
                thr_state[tid] = TS_EXITED;
            end
            CMD_RESCHEDULE: begin
                dropped = 1'b0;
                if (thr_state[tid] != TS_EXITED && thr_state[tid] != TS_WAITING)
                    dropped = !ready_slot_insert(tid);
                // Pop round-robin, throwing away exited threads, until a live
                // one turns up or the table runs dry.
                picked  = 1'b0;
                popping = 1'b1;
                while (popping) begin
                    popping = 1'b0;
                    for (int k = 0; k < SLOTS; k++) begin
                        p = (rdy_ptr + k) % SLOTS;
                        if (rdy_used[p]) begin
                            rdy_used[p] = 1'b0;
                            rdy_cnt--;
                            rdy_ptr = 4'((p + 1) % SLOTS);
                            t       = rdy_tid[p];
                            picked  = (thr_state[t] != TS_EXITED);
                            popping = !picked;
                            break;
                        end
                    end
                end
                if (picked) begin
                    run_thread = t;
                    r.thread   = t;
                    r.status   = dropped ? ST_DROPPED : ST_DONE;
                end else begin
                    r.status = ST_NONE;
                end
            end
            CMD_FIND_THREAD: begin
                r.status = ST_NONE;
                for (int i = 0; i < SLOTS; i++)
                    if (rdy_used[i] && rdy_tid[i] == tid)
                        r.status = ST_DONE;
                for (int i = 0; i < SLOTS; i++)
                    if (wt_used[i] && wt_tid[i] == tid)
                        r.status = ST_DONE;
                if (r.status == ST_DONE)
                    r.thread = tid;
            end
            default: begin
                // Unused codes change nothing and report done with thread 0.
            end
        endcase
        r.ready   = rdy_cnt;
        r.waiting = wt_cnt;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic sched_cmd_t make_cmd(input logic [CMD_W-1:0] cmd,
                                            input logic [TID_W-1:0] tid,
                                            input logic [EV_IN_W-1:0] ev);
        sched_cmd_t c;
        c.pad       = 1'b0;
        c.event_tag = ev;
        c.thread_id = tid;
        c.cmd       = cmd;
        return c;
    endfunction

    // Events mostly come from a small pool so that wake-ups find waiters;
    // a quarter are fully random so every tag bit toggles.
    function automatic logic [EV_IN_W-1:0] pick_event();
        if ($urandom_range(0, 3) == 0)
            return EV_IN_W'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h5A;
            default: return 8'hA5;
        endcase
    endfunction

    function automatic logic [TID_W-1:0] pick_thread();
        return TID_W'($urandom_range(0, NUM_THREADS - 1));
    endfunction

    task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [TID_W-1:0] tid,
                           input logic [EV_IN_W-1:0] ev);
        dir_row_t row;
        row.item  = make_cmd(cmd, tid, ev);
        row.typed = 1'b0;
        row.want  = '0;
        dir_rows.push_back(row);
    endtask

    task automatic add_typed_row(input logic [CMD_W-1:0] cmd,
                                 input logic [TID_W-1:0] tid,
                                 input logic [EV_IN_W-1:0] ev,
                                 input logic [STATUS_W-1:0] st,
                                 input logic [TID_W-1:0] th,
                                 input logic [COUNT_W-1:0] rc,
                                 input logic [COUNT_W-1:0] wc);
        dir_row_t row;
        row.item         = make_cmd(cmd, tid, ev);
        row.typed        = 1'b1;
        row.want.status  = st;
        row.want.thread  = th;
        row.want.ready   = rc;
        row.want.waiting = wc;
        dir_rows.push_back(row);
    endtask

    // Present one command, optionally after an idle burst, and hold it until
    // the block takes the transfer. The model runs at the accepting edge, and
    // a typed result, where given, replaces the model's expectation.
    task automatic issue_command(input sched_cmd_t item, input bit typed,
                                 input sched_result_t want);
        sched_result_t model;
        int            idle;
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            idle = $urandom_range(1, 19);
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= item;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        model = predict_schedule(item);
        sched_results_due.push_back(typed ? want : model);
        n_commands++;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            n_mismatch++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Reset and stimulus
    // ------------------------------------------------------------------------

    initial begin
        int               n_rep;
        logic [TID_W-1:0] t;

        for (int i = 0; i < SLOTS; i++) begin
            rdy_used[i] = 1'b0;
            rdy_tid[i]  = '0;
            wt_used[i]  = 1'b0;
            wt_tid[i]   = '0;
            wt_ev[i]    = '0;
        end
        for (int i = 0; i < NUM_THREADS; i++)
            thr_state[i] = TS_IDLE;
        rdy_ptr    = '0;
        rdy_cnt    = '0;
        wt_ptr     = '0;
        wt_cnt     = '0;
        run_thread = '0;

        // Directed commands. Results are typed in while the tables are
        // trivially small; later rows lean on the model.
        add_typed_row(CMD_FIND_THREAD, 4'd5,  8'h00, ST_NONE, 4'd0,  5'd0, 5'd0);
        // Thread 0 is requeued and immediately popped back out.
        add_typed_row(CMD_RESCHEDULE,  4'd0,  8'h00, ST_DONE, 4'd0,  5'd0, 5'd0);
        add_typed_row(CMD_WAKE_EVENT,  4'd15, 8'hFF, ST_NONE, 4'd0,  5'd0, 5'd0);
        add_typed_row(CMD_UNUSED_6,    4'd15, 8'hFF, ST_DONE, 4'd0,  5'd0, 5'd0);
        add_typed_row(CMD_UNUSED_7,    4'd0,  8'h00, ST_DONE, 4'd0,  5'd0, 5'd0);
        add_typed_row(CMD_SET_READY,   4'd15, 8'h00, ST_DONE, 4'd15, 5'd1, 5'd0);
        add_typed_row(CMD_SET_WAITING, 4'd3,  8'hAA, ST_DONE, 4'd3,  5'd1, 5'd1);
        // A thread already waiting, or already ready, is left alone.
        add_typed_row(CMD_SET_WAITING, 4'd3,  8'h55, ST_DONE, 4'd3,  5'd1, 5'd1);
        add_typed_row(CMD_SET_READY,   4'd15, 8'h00, ST_DONE, 4'd15, 5'd1, 5'd1);
        add_typed_row(CMD_SET_EXIT,    4'd15, 8'h00, ST_DONE, 4'd15, 5'd1, 5'd1);
        // Only an exited thread is queued: it is discarded, nothing runs.
        add_typed_row(CMD_RESCHEDULE,  4'd15, 8'h00, ST_NONE, 4'd0,  5'd0, 5'd1);
        add_row(CMD_WAKE_EVENT,  4'd0,  8'h55);
        add_row(CMD_WAKE_EVENT,  4'd0,  8'hAA);
        add_row(CMD_FIND_THREAD, 4'd3,  8'h00);
        // Exited thread made ready, then made waiting.
        add_row(CMD_SET_READY,   4'd15, 8'h00);
        add_row(CMD_SET_WAITING, 4'd15, 8'h00);
        add_row(CMD_SET_READY,   4'd7,  8'hFF);
        // Rescheduling a thread that is already ready queues it a second time.
        add_row(CMD_RESCHEDULE,  4'd7,  8'h00);
        add_row(CMD_FIND_THREAD, 4'd7,  8'h00);
        add_row(CMD_FIND_THREAD, 4'd15, 8'hFF);
        add_row(CMD_SET_WAITING, 4'd0,  8'h00);
        // Two waiters on one event are woken in round-robin order.
        add_row(CMD_WAKE_EVENT,  4'd15, 8'h00);
        add_row(CMD_WAKE_EVENT,  4'd15, 8'h00);
        add_row(CMD_SET_EXIT,    4'd0,  8'h00);
        add_row(CMD_RESCHEDULE,  4'd0,  8'h00);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        gap_pct = 20;
        foreach (dir_rows[i])
            issue_command(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

        // Random episodes. Filling a table takes a run of inserts of one
        // exited thread, so most of the traffic is such runs, drains of the
        // tables, and single commands with random content in between.
        while (n_commands < ITEMS) begin
            if (n_commands >= ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 2))
                    0:       gap_pct = 0;
                    1:       gap_pct = 15;
                    default: gap_pct = 45;
                endcase
            end
            case ($urandom_range(0, 9))
                0: begin
                    // Fill the ready table with copies of one exited thread,
                    // sometimes behind a live one, then reschedule into it.
                    t = pick_thread();
                    issue_command(make_cmd(CMD_SET_EXIT, t, pick_event()), 1'b0, '0);
                    if ($urandom_range(0, 1) == 0)
                        issue_command(make_cmd(CMD_SET_READY, pick_thread(), pick_event()),
                                      1'b0, '0);
                    repeat (17)
                        issue_command(make_cmd(CMD_SET_READY, t, pick_event()), 1'b0, '0);
                    n_rep = $urandom_range(1, 4);
                    repeat (n_rep)
                        issue_command(make_cmd(CMD_RESCHEDULE, pick_thread(), pick_event()),
                                      1'b0, '0);
                end
                1: begin
                    // Fill the waiting table: waiting then exit lets one
                    // thread take a fresh waiting slot each time.
                    t = pick_thread();
                    repeat (17) begin
                        issue_command(make_cmd(CMD_SET_WAITING, t, pick_event()), 1'b0, '0);
                        issue_command(make_cmd(CMD_SET_EXIT, t, pick_event()), 1'b0, '0);
                    end
                    n_rep = $urandom_range(1, 6);
                    repeat (n_rep)
                        issue_command(make_cmd(CMD_WAKE_EVENT, pick_thread(), pick_event()),
                                      1'b0, '0);
                end
                2: begin
                    n_rep = $urandom_range(8, 24);
                    repeat (n_rep) begin
                        if ($urandom_range(0, 1) == 0)
                            issue_command(make_cmd(CMD_RESCHEDULE, pick_thread(),
                                                   pick_event()), 1'b0, '0);
                        else
                            issue_command(make_cmd(CMD_WAKE_EVENT, pick_thread(),
                                                   pick_event()), 1'b0, '0);
                    end
                end
                default: begin
                    logic [CMD_W-1:0] c;
                    case ($urandom_range(0, 21))
                        0, 1, 2, 3:         c = CMD_SET_READY;
                        4, 5, 6, 7:         c = CMD_SET_WAITING;
                        8, 9, 10:           c = CMD_WAKE_EVENT;
                        11, 12:             c = CMD_SET_EXIT;
                        13, 14, 15, 16, 17: c = CMD_RESCHEDULE;
                        18, 19:             c = CMD_FIND_THREAD;
                        20:                 c = CMD_UNUSED_6;
                        default:            c = CMD_UNUSED_7;
                    endcase
                    issue_command(make_cmd(c, pick_thread(), pick_event()), 1'b0, '0);
                end
            endcase
        end
        s_tvalid <= 1'b0;

        // Let the last results drain, then give the block time to show any
        // result that nobody asked for.
        while (sched_results_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Ran %0d commands (%0d directed); %0d results checked.",
                 n_commands, dir_rows.size(), n_results);
        $display("Results seen: %0d dropped inserts, %0d none found.", n_dropped, n_none);
        if (n_mismatch == 0 && sched_results_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts, none once the run enters its last part.
    // ------------------------------------------------------------------------
    initial begin
        int hold;
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 15) == 0) begin
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 20;
                    default: stall_pct = 50;
                endcase
            end
            if (!quiet && $urandom_range(0, 99) < stall_pct) begin
                hold = $urandom_range(1, 19);
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            hold = $urandom_range(1, 8);
            m_tready <= 1'b1;
            repeat (hold) @(posedge aclk);
        end
    end

    // ------------------------------------------------------------------------
    // Result checking: every result transfer against the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        sched_result_t got;
        sched_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            n_results++;
            if (got.status == ST_DROPPED)
                n_dropped++;
            if (got.status == ST_NONE)
                n_none++;
            if (sched_results_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                n_mismatch++;
            end else begin
                want = sched_results_due.pop_front();
                check_field("status",        want.status,  got.status);
                check_field("thread_out",    want.thread,  got.thread);
                check_field("ready_count",   want.ready,   got.ready);
                check_field("waiting_count", want.waiting, got.waiting);
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #(RUN_LIMIT_NS);
        $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/sts_pkg.sv
rtl/core/sts_slot_table.sv
rtl/core/sts_ctrl.sv
rtl/core/slot_table_thread_scheduler.sv
rtl/core/sts_checker.sv
bench/slot_table_thread_scheduler_tb.sv
